// ===== design/ppurp_pkg.sv =====
// Package: operation and register codes, item types for the register port.
`default_nettype none
package ppurp_pkg;
	localparam int SPRITE_BYTES = 256;
	localparam int PALETTE_ENTRIES = 32;
	localparam int SA_W = $clog2(SPRITE_BYTES);
	localparam int PAL_W = $clog2(PALETTE_ENTRIES);

	localparam logic [2:0] OP_REG_WRITE  = 3'd0;
	localparam logic [2:0] OP_REG_READ   = 3'd1;
	localparam logic [2:0] OP_VBLANK_ON  = 3'd2;
	localparam logic [2:0] OP_VBLANK_OFF = 3'd3;
	localparam logic [2:0] OP_VRAM_RET   = 3'd4;
	localparam logic [2:0] OP_SPR0_HIT   = 3'd5;
	localparam logic [2:0] OP_OVERFLOW   = 3'd6;

	localparam logic [2:0] REG_CTRL0  = 3'd0;
	localparam logic [2:0] REG_CTRL1  = 3'd1;
	localparam logic [2:0] REG_STATUS = 3'd2;
	localparam logic [2:0] REG_SPRADR = 3'd3;
	localparam logic [2:0] REG_SPRDAT = 3'd4;
	localparam logic [2:0] REG_SCROLL = 3'd5;
	localparam logic [2:0] REG_ADDR   = 3'd6;
	localparam logic [2:0] REG_DATA   = 3'd7;

	typedef struct packed {
		logic [2:0] operation;
		logic [2:0] reg_index;
		logic [7:0] write_data;
		logic       in_visible_line;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        read_valid;
		logic        nmi_level;
		logic        vram_read_request;
		logic        vram_write_request;
		logic [13:0] vram_address;
		logic [7:0]  vram_data;
		logic [14:0] current_scroll_address;
		logic [2:0]  fine_x_scroll;
	} out_item_t;

	// classified item passed from front to back
	typedef struct packed {
		logic [2:0] operation;
		logic [2:0] reg_index;
		logic [7:0] write_data;
		logic       in_visible_line;
	} cmd_t;
endpackage
`default_nettype wire

// ===== design/ppurp_if.sv =====
// Interfaces: item channel and configuration write channel.
`default_nettype none
interface ppurp_in_if;
	logic valid;
	logic ready;
	logic [2:0] operation;
	logic [2:0] reg_index;
	logic [7:0] write_data;
	logic       in_visible_line;
	modport source (output valid, operation, reg_index, write_data, in_visible_line,
		input ready);
	modport sink (input valid, operation, reg_index, write_data, in_visible_line,
		output ready);
endinterface

interface ppurp_out_if;
	logic valid;
	logic ready;
	logic [7:0]  read_data;
	logic        read_valid;
	logic        nmi_level;
	logic        vram_read_request;
	logic        vram_write_request;
	logic [13:0] vram_address;
	logic [7:0]  vram_data;
	logic [14:0] current_scroll_address;
	logic [2:0]  fine_x_scroll;
	modport source (output valid, read_data, read_valid, nmi_level, vram_read_request,
		vram_write_request, vram_address, vram_data, current_scroll_address,
		fine_x_scroll, input ready);
	modport sink (input valid, read_data, read_valid, nmi_level, vram_read_request,
		vram_write_request, vram_address, vram_data, current_scroll_address,
		fine_x_scroll, output ready);
endinterface

interface ppurp_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/ppurp_front.sv =====
// Front: accept items and queue them in a two-entry FIFO.
`default_nettype none
module ppurp_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire ppurp_pkg::cmd_t in_cmd,
	output logic                 q_valid,
	input  wire logic            q_pop,
	output ppurp_pkg::cmd_t      q_cmd
);
	ppurp_pkg::cmd_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = mem_q[rp_q];

	// store entry
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_cmd;
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

// ===== design/ppurp_back.sv =====
// Back: execute items against register state and register the result.
`default_nettype none
module ppurp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       security,
	input  wire logic             q_valid,
	output logic                  q_pop,
	input  wire ppurp_pkg::cmd_t  q_cmd,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output ppurp_pkg::out_item_t  out_item
);
	logic [7:0]  ctrl0_q, ctrl1_q, status_q, spradr_q;
	logic [7:0]  sam_q [ppurp_pkg::SPRITE_BYTES];
	logic [ppurp_pkg::SPRITE_BYTES-1:0] sam_vld_q;
	logic [7:0]  sam_rd_q;
	logic        sam_hit_q;
	logic [5:0]  pal_q [ppurp_pkg::PALETTE_ENTRIES];
	logic [14:0] t_q, v_q;
	logic        toggle_q;
	logic [2:0]  fx_q;
	logic [7:0]  latch_q, rbuf_q;
	logic        ovalid_q;
	ppurp_pkg::out_item_t o_q;

	// next-state values
	logic [7:0]  ctrl0_n, ctrl1_n, status_n, spradr_n, latch_n, rbuf_n, d, rd;
	logic [14:0] t_n, v_n;
	logic        toggle_n;
	logic [2:0]  fx_n, r;
	logic [13:0] a;
	logic        sam_we, pal_we, pal_bd;
	logic [7:0]  sam_wd;
	logic [ppurp_pkg::SA_W-1:0] sam_ra;
	logic [5:0]  pal_wd;
	logic [7:0]  stat_rd;
	ppurp_pkg::out_item_t o_n;

	assign q_pop     = q_valid && (!ovalid_q || out_ready);
	assign out_valid = ovalid_q;
	assign out_item  = o_q;
	assign a         = v_q[13:0];
	// read ahead at the sprite address that holds after this edge
	assign sam_ra    = q_pop ? spradr_n : spradr_q;

	always_comb begin
		ctrl0_n = ctrl0_q; ctrl1_n = ctrl1_q; status_n = status_q; spradr_n = spradr_q;
		latch_n = latch_q; rbuf_n = rbuf_q; t_n = t_q; v_n = v_q;
		toggle_n = toggle_q; fx_n = fx_q;
		sam_we = 1'b0; sam_wd = q_cmd.write_data;
		pal_we = 1'b0; pal_bd = 1'b0; pal_wd = q_cmd.write_data[5:0];
		d = q_cmd.write_data; rd = 8'd0; r = q_cmd.reg_index; stat_rd = 8'd0;
		o_n = '0;
		case (q_cmd.operation)
			ppurp_pkg::OP_REG_WRITE: begin
				if (security != 8'd0 && r[2:1] == 2'b00) r[0] = ~r[0];
				case (r)
					ppurp_pkg::REG_CTRL0: begin
						ctrl0_n = d;
						t_n[11:10] = d[1:0];
					end
					ppurp_pkg::REG_CTRL1: ctrl1_n = d;
					ppurp_pkg::REG_SPRADR: spradr_n = d;
					ppurp_pkg::REG_SPRDAT: begin
						if (q_cmd.in_visible_line && ctrl1_q[4]) d = 8'hff;
						else if (spradr_q[1:0] == 2'd2) d = d & 8'he3;
						sam_we = 1'b1; sam_wd = d;
						spradr_n = spradr_q + 8'd1;
					end
					ppurp_pkg::REG_SCROLL: begin
						toggle_n = ~toggle_q;
						if (!toggle_q) begin
							t_n[4:0] = d[7:3];
							fx_n = d[2:0];
						end else begin
							t_n[9:5] = d[7:3];
							t_n[14:12] = d[2:0];
						end
					end
					ppurp_pkg::REG_ADDR: begin
						toggle_n = ~toggle_q;
						if (!toggle_q) t_n = {1'b0, d[5:0], t_q[7:0]};
						else begin
							t_n = {t_q[14:8], d};
							v_n = {t_q[14:8], d};
						end
					end
					ppurp_pkg::REG_DATA: begin
						v_n = v_q + (ctrl0_q[2] ? 15'd32 : 15'd1);
						if (a >= 14'h3f00) begin
							pal_wd = d[5:0];
							pal_we = (a[1:0] != 2'd0);
							pal_bd = (a[3:0] == 4'd0);
						end else begin
							o_n.vram_write_request = 1'b1;
							o_n.vram_address = a;
							o_n.vram_data = d;
						end
					end
					default: ;
				endcase
				latch_n = d;
			end
			ppurp_pkg::OP_REG_READ: begin
				o_n.read_valid = 1'b1;
				case (r)
					ppurp_pkg::REG_STATUS: begin
						stat_rd = (security != 8'd0) ? ((status_q & 8'hc0) | security)
							: (status_q | (latch_q & 8'h1f));
						latch_n = stat_rd;
						toggle_n = 1'b0;
						if (stat_rd[7]) status_n = status_q & 8'h7f;
						rd = stat_rd;
					end
					ppurp_pkg::REG_SPRDAT: begin
						latch_n = sam_hit_q ? sam_rd_q : 8'd0;
						rd = latch_n;
					end
					ppurp_pkg::REG_DATA: begin
						v_n = v_q + (ctrl0_q[2] ? 15'd32 : 15'd1);
						if (a >= 14'h3f00) begin
							rd = {2'b00, pal_q[a[4:0]]} & (ctrl1_q[0] ? 8'hf0 : 8'hff);
						end else begin
							latch_n = rbuf_q;
							rd = rbuf_q;
							o_n.vram_read_request = 1'b1;
							o_n.vram_address = a;
						end
					end
					default: rd = latch_q;
				endcase
				o_n.read_data = rd;
			end
			ppurp_pkg::OP_VBLANK_ON:  status_n = status_q | 8'h80;
			ppurp_pkg::OP_VBLANK_OFF: status_n = status_q & 8'h3f;
			ppurp_pkg::OP_VRAM_RET:   rbuf_n = d;
			ppurp_pkg::OP_SPR0_HIT:   status_n = status_q | 8'h40;
			ppurp_pkg::OP_OVERFLOW:   status_n = {status_q[7:6], d[0], status_q[4:0]};
			default: ;
		endcase
		o_n.nmi_level = ctrl0_n[7] && status_n[7];
		o_n.current_scroll_address = v_n;
		o_n.fine_x_scroll = fx_n;
	end

	// sprite attribute memory: write at the sprite address, read the next one
	always_ff @(posedge clk) begin
		if (q_pop && sam_we) sam_q[spradr_q] <= sam_wd;
		sam_rd_q <= sam_q[sam_ra];
	end

	// mark written sprite bytes so unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sam_vld_q <= '0;
			sam_hit_q <= 1'b0;
		end else begin
			if (q_pop && sam_we) sam_vld_q[spradr_q] <= 1'b1;
			sam_hit_q <= sam_vld_q[sam_ra];
		end
	end

	// palette store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppurp_pkg::PALETTE_ENTRIES; i++)
				pal_q[i] <= (i % 4 != 0) ? 6'(i) : 6'd0;
		end else if (q_pop) begin
			if (pal_we) pal_q[a[4:0]] <= pal_wd;
			if (pal_bd)
				for (int i = 0; i < ppurp_pkg::PALETTE_ENTRIES; i += 4) pal_q[i] <= pal_wd;
		end
	end

	// register state and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl0_q <= '0; ctrl1_q <= '0; status_q <= '0; spradr_q <= '0;
			latch_q <= '0; rbuf_q <= 8'hff; t_q <= '0; v_q <= '0;
			toggle_q <= 1'b0; fx_q <= '0;
			ovalid_q <= 1'b0; o_q <= '0;
		end else begin
			if (q_pop) begin
				ctrl0_q <= ctrl0_n; ctrl1_q <= ctrl1_n; status_q <= status_n;
				spradr_q <= spradr_n; latch_q <= latch_n; rbuf_q <= rbuf_n;
				t_q <= t_n; v_q <= v_n; toggle_q <= toggle_n; fx_q <= fx_n;
				o_q <= o_n;
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/ppu_register_port.sv =====
// Top level: processor-side register port of the picture unit.
// Channels: in (bus events: register write/read, status events, returned
// video memory bytes), out (one result item per input item), cfg (writes
// the security id byte; always ready, write only while idle).
// Path: an item is written into a two-entry queue, then the execute stage
// updates state and loads the output register, which presents the result
// until out takes it.
// Throughput: one item per cycle while out is ready, set by the single
// execute stage that reads and writes all register state.
// Reset: registers clear, palette takes its index pattern (backdrop
// entries zero), read buffer is 0xff, sprite memory reads as zero.
// Stall: when out is not ready the output register holds; the queue
// absorbs two more items, then in.ready drops.
`default_nettype none
module ppu_register_port (
	input wire logic clk,
	input wire logic arst_n,
	ppurp_in_if.sink   in,
	ppurp_out_if.source out,
	ppurp_cfg_if.sink  cfg
);
	ppurp_pkg::cmd_t in_cmd, q_cmd;
	ppurp_pkg::out_item_t oi;
	logic q_valid, q_pop;
	logic [7:0] security_q;

	assign in_cmd = '{operation: in.operation, reg_index: in.reg_index,
		write_data: in.write_data, in_visible_line: in.in_visible_line};
	assign cfg.ready = 1'b1;

	// hold security id
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) security_q <= 8'd0;
		else if (cfg.valid) security_q <= cfg.data;
	end

	ppurp_front u_front (.clk, .arst_n, .in_valid(in.valid), .in_ready(in.ready),
		.in_cmd, .q_valid, .q_pop, .q_cmd);

	ppurp_back u_back (.clk, .arst_n, .security(security_q), .q_valid, .q_pop, .q_cmd,
		.out_valid(out.valid), .out_ready(out.ready), .out_item(oi));

	assign out.read_data = oi.read_data;
	assign out.read_valid = oi.read_valid;
	assign out.nmi_level = oi.nmi_level;
	assign out.vram_read_request = oi.vram_read_request;
	assign out.vram_write_request = oi.vram_write_request;
	assign out.vram_address = oi.vram_address;
	assign out.vram_data = oi.vram_data;
	assign out.current_scroll_address = oi.current_scroll_address;
	assign out.fine_x_scroll = oi.fine_x_scroll;
endmodule
`default_nettype wire

// ===== design/ppurp_checker.sv =====
// Checker: port-level properties of the register port, bound to the top.
`default_nettype none
module ppurp_port_props (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic read_valid,
	input wire logic [7:0] read_data,
	input wire logic vram_read_request,
	input wire logic vram_write_request,
	input wire logic [13:0] vram_address
);
	// never request both directions
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(vram_read_request && vram_write_request))
		else $error("both vram requests");
	// read request only comes from a read
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && vram_read_request |-> read_valid)
		else $error("read request without read");
	// no address without request
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !vram_read_request && !vram_write_request |-> vram_address == 14'd0)
		else $error("stray address");
	// non-read returns zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !read_valid |-> read_data == 8'd0)
		else $error("stray read data");
	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data))
		else $error("result dropped");
endmodule

bind ppu_register_port ppurp_port_props u_chk (.clk, .arst_n, .out_valid(out.valid),
	.out_ready(out.ready), .read_valid(out.read_valid), .read_data(out.read_data),
	.vram_read_request(out.vram_read_request), .vram_write_request(out.vram_write_request),
	.vram_address(out.vram_address));
`default_nettype wire
